### design/strict_base64_key_decoder_macros.svh
// assertion macros for the strict base64 key decoder
`ifndef STRICT_BASE64_KEY_DECODER_MACROS_SVH
`define STRICT_BASE64_KEY_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SBKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sbkd_pkg.sv
// shared types, constants and the alphabet lookup of the base64 key decoder
`timescale 1ns / 1ps
package sbkd_pkg;

  localparam int unsigned StrLen  = 88;
  localparam int unsigned DataLen = 86;
  localparam int unsigned PosW    = 7;
  localparam int unsigned SextW   = 6;

  localparam logic [PosW-1:0] PosLastData = PosW'(DataLen - 1);
  localparam logic [PosW-1:0] PosData     = PosW'(DataLen);
  localparam logic [PosW-1:0] PosLastPad  = PosW'(StrLen - 1);
  localparam logic [PosW-1:0] PosEnd      = PosW'(StrLen);

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChPad    = 8'h3d;

  localparam logic [7:0] OffLower = 8'd26;
  localparam logic [7:0] OffDigit = 8'd52;
  localparam logic [5:0] SextPlus  = 6'd62;
  localparam logic [5:0] SextSlash = 6'd63;

  // phase of a character within its group of four
  typedef enum logic [1:0] {
    PhaseLead  = 2'd0,
    PhaseFirst = 2'd1,
    PhaseSecnd = 2'd2,
    PhaseThird = 2'd3
  } phase_e;

  // one queued request from front to back
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       is_end;
    logic       valid_res;
  } work_t;

  // alphabet lookup: bit 6 set means the character is not in the alphabet
  function automatic logic [SextW:0] sextet_of(input logic [7:0] c);
    logic [SextW:0] r;
    r = {1'b1, SextW'(0)};
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = {1'b0, 6'(c - ChUpperA)};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      r = {1'b0, 6'(c - ChLowerA + OffLower)};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      r = {1'b0, 6'(c - ChDigit0 + OffDigit)};
    end else if (c == ChPlus) begin
      r = {1'b0, SextPlus};
    end else if (c == ChSlash) begin
      r = {1'b0, SextSlash};
    end
    return r;
  endfunction

endpackage

### design/sbkd_front.sv
// front part: takes characters, tracks position and faults, builds requests
`timescale 1ns / 1ps
module sbkd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    text_char_i,
  input  logic          last_char_i,
  input  logic          q_full_i,
  output logic          full_o,
  output logic          rec_push_o,
  output sbkd_pkg::work_t rec_o
);
  import sbkd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [SextW-1:0] prior_q, prior_d;
  logic             fault_q, fault_d;
  logic             accept;
  logic [SextW:0]   sx;
  logic [SextW-1:0] v;
  logic             bad, in_data, in_pad, emit, fault_nx;
  logic [7:0]       byte_val;
  phase_e           phase;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  // classify the character
  assign sx      = sextet_of(text_char_i);
  assign bad     = sx[SextW];
  assign v       = sx[SextW-1:0];
  assign in_data = pos_q < PosData;
  assign in_pad  = !in_data && (pos_q < PosEnd);
  assign phase   = phase_e'(pos_q[1:0]);
  assign emit    = in_data && !bad && (phase != PhaseLead);

  // assemble the byte from the prior sextet and this one
  always_comb begin
    unique case (phase)
      PhaseFirst: byte_val = {prior_q, v[5:4]};
      PhaseSecnd: byte_val = {prior_q[3:0], v[5:2]};
      PhaseThird: byte_val = {prior_q[1:0], v};
      default:    byte_val = 8'd0;
    endcase
  end

  // sticky fault including this character
  assign fault_nx = fault_q
                 || (in_data && bad)
                 || (pos_q == PosLastData && !bad && (v[3:0] != 4'd0))
                 || (in_pad && text_char_i != ChPad)
                 || (pos_q >= PosEnd)
                 || (last_char_i && pos_q != PosLastPad);

  // request toward the back
  assign rec_push_o      = accept && (emit || last_char_i);
  assign rec_o.has_byte  = emit;
  assign rec_o.data_byte = byte_val;
  assign rec_o.is_end    = last_char_i;
  assign rec_o.valid_res = !fault_nx;

  // next state
  always_comb begin
    pos_d   = pos_q;
    prior_d = prior_q;
    fault_d = fault_q;
    if (accept) begin
      if (last_char_i) begin
        pos_d   = '0;
        prior_d = '0;
        fault_d = 1'b0;
      end else begin
        if (pos_q < PosEnd) pos_d = pos_q + PosW'(1);
        if (in_data) prior_d = bad ? '0 : v;
        fault_d = fault_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      prior_q <= '0;
      fault_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      prior_q <= prior_d;
      fault_q <= fault_d;
    end
  end

endmodule

### design/sbkd_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps
module sbkd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbkd_pkg::work_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbkd_pkg::work_t rdata_o,
  output logic            empty_o
);
  import sbkd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### design/sbkd_back.sv
// back part: turns queued requests into results in an output register
`timescale 1ns / 1ps
module sbkd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbkd_pkg::work_t rec_i,
  input  logic            rec_empty_i,
  output logic            rec_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      data_byte_o,
  output logic            is_end_o,
  output logic            valid_res_o
);
  import sbkd_pkg::*;

  logic       out_v_q, out_v_d;
  logic [7:0] byte_q, byte_d;
  logic       end_q, end_d;
  logic       ok_q, ok_d;
  logic       half_q, half_d;
  logic       load, byte_turn;

  assign load      = !out_v_q || pop;
  assign byte_turn = rec_i.has_byte && !half_q;

  // pick the next result of the head request
  always_comb begin
    out_v_d   = out_v_q;
    byte_d    = byte_q;
    end_d     = end_q;
    ok_d      = ok_q;
    half_d    = half_q;
    rec_pop_o = 1'b0;
    if (load) begin
      out_v_d = !rec_empty_i;
      if (!rec_empty_i) begin
        if (byte_turn) begin
          byte_d = rec_i.data_byte;
          end_d  = 1'b0;
          ok_d   = 1'b0;
          if (rec_i.is_end) half_d = 1'b1;
          else rec_pop_o = 1'b1;
        end else begin
          byte_d    = 8'd0;
          end_d     = 1'b1;
          ok_d      = rec_i.valid_res;
          half_d    = 1'b0;
          rec_pop_o = 1'b1;
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    end_q  <= end_d;
    ok_q   <= ok_d;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      half_q  <= half_d;
    end
  end

  assign empty       = !out_v_q;
  assign data_byte_o = byte_q;
  assign is_end_o    = end_q;
  assign valid_res_o = ok_q;

endmodule

### design/strict_base64_key_decoder.sv
// top level of the strict base64 key decoder
//
//   channel   direction  handshake            payload
//   input     in         push / full          text_char_i, last_char_i
//   result    out        empty / pop          data_byte_o, is_end_o, valid_res_o
//
// one character is taken per cycle while full is low; each yields zero, one or two results
// a result is registered on its way out: the front writes it into the queue,
// and the back moves it into the output register
// the last character at the final data position yields two results, its byte and then the end result
// full follows the request queue only; reset clears position, faults and queue
`timescale 1ns / 1ps
`include "strict_base64_key_decoder_macros.svh"
module strict_base64_key_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char_i,
  input  logic       last_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       is_end_o,
  output logic       valid_res_o
);
  import sbkd_pkg::*;

  work_t rec_in, rec_out;
  logic  rec_push, q_full, q_empty, rec_pop;

  // front: decode and fault tracking
  sbkd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .text_char_i (text_char_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  // request queue
  sbkd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .full_o  (q_full),
    .pop_i   (rec_pop),
    .rdata_o (rec_out),
    .empty_o (q_empty)
  );

  // back: result sequencing
  sbkd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_empty_i (q_empty),
    .rec_pop_o   (rec_pop),
    .empty       (empty),
    .pop         (pop),
    .data_byte_o (data_byte_o),
    .is_end_o    (is_end_o),
    .valid_res_o (valid_res_o)
  );

  // checks
  `SBKD_ASSERT_IMP(a_no_push_full, rec_push, !q_full, "request pushed into a full queue")
  `SBKD_ASSERT_IMP(a_no_pop_empty, rec_pop, !q_empty, "request popped from an empty queue")
  `SBKD_ASSERT_IMP(a_end_byte_zero, !empty && is_end_o, data_byte_o == 8'd0, "end result carries a byte")
  `SBKD_ASSERT_IMP(a_data_no_verdict, !empty && !is_end_o, !valid_res_o, "data result carries a verdict")

endmodule
